// File: hdl/e2r_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler angle to rotation matrix block.
`default_nettype none
package e2r_pkg;

  typedef logic signed [31:0] q28_t;
  typedef logic signed [33:0] sum_t;

  localparam int HALF_TURN    = 180 * 128;
  localparam int FULL_TURN    = 2 * HALF_TURN;
  localparam int QUARTER_TURN = HALF_TURN / 2;
  localparam int WORK_FRAC    = 28;
  localparam int ATAN_ENTRIES = 24;
  localparam q28_t CORDIC_GAIN = 32'sd163008218;

  typedef struct packed {
    q28_t s;
    q28_t c;
  } sincos_t;

  function automatic q28_t atan_q23(input logic [4:0] idx);
    q28_t v;
    case (idx)
      5'd0:  v = 32'sd377487360;
      5'd1:  v = 32'sd222843801;
      5'd2:  v = 32'sd117744544;
      5'd3:  v = 32'sd59768969;
      5'd4:  v = 32'sd30000467;
      5'd5:  v = 32'sd15014858;
      5'd6:  v = 32'sd7509261;
      5'd7:  v = 32'sd3754860;
      5'd8:  v = 32'sd1877459;
      5'd9:  v = 32'sd938733;
      5'd10: v = 32'sd469367;
      5'd11: v = 32'sd234683;
      5'd12: v = 32'sd117342;
      5'd13: v = 32'sd58671;
      5'd14: v = 32'sd29335;
      5'd15: v = 32'sd14668;
      5'd16: v = 32'sd7334;
      5'd17: v = 32'sd3667;
      5'd18: v = 32'sd1833;
      5'd19: v = 32'sd917;
      5'd20: v = 32'sd458;
      5'd21: v = 32'sd229;
      5'd22: v = 32'sd115;
      5'd23: v = 32'sd57;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Q28 product rounded half up.
  function automatic q28_t qmul(input q28_t a, input q28_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (WORK_FRAC - 1));
    return p[WORK_FRAC+31:WORK_FRAC];
  endfunction

endpackage
`default_nettype wire

// File: hdl/e2r_fold.sv
// Angle reduction stage: wraps to one turn and folds into a quarter turn each way.
`default_nettype none
module e2r_fold (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] angle,
  output e2r_pkg::q28_t           z_r,
  output logic                    neg_cos_r
);

  logic signed [16:0] a_wrap;
  logic signed [16:0] a_fold;
  logic               neg_nxt;
  e2r_pkg::q28_t      z_nxt;

  always_comb begin
    a_wrap = 17'(angle);
    if (a_wrap > 17'(e2r_pkg::HALF_TURN)) begin
      a_wrap = a_wrap - 17'(e2r_pkg::FULL_TURN);
    end else if (a_wrap <= -17'(e2r_pkg::HALF_TURN)) begin
      a_wrap = a_wrap + 17'(e2r_pkg::FULL_TURN);
    end
    a_fold  = a_wrap;
    neg_nxt = 1'b0;
    if (a_wrap > 17'(e2r_pkg::QUARTER_TURN)) begin
      a_fold  = 17'(e2r_pkg::HALF_TURN) - a_wrap;
      neg_nxt = 1'b1;
    end else if (a_wrap < -17'(e2r_pkg::QUARTER_TURN)) begin
      a_fold  = -17'(e2r_pkg::HALF_TURN) - a_wrap;
      neg_nxt = 1'b1;
    end
    z_nxt = 32'(a_fold) <<< 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r       <= z_nxt;
      neg_cos_r <= neg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/e2r_cordic.sv
// Pipelined rotation-mode CORDIC, one register stage per iteration.
`default_nettype none
module e2r_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire e2r_pkg::q28_t z_in,
  input  wire logic          neg_cos_in,
  output e2r_pkg::sincos_t   sc
);

  e2r_pkg::q28_t x_r [STEPS];
  e2r_pkg::q28_t y_r [STEPS];
  e2r_pkg::q28_t z_r [STEPS];
  logic          neg_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    e2r_pkg::q28_t xs, ys, zs, dx, dy, ang;
    logic          ns;
    if (i == 0) begin : g_first
      assign xs = e2r_pkg::CORDIC_GAIN;
      assign ys = '0;
      assign zs = z_in;
      assign ns = neg_cos_in;
    end else begin : g_next
      assign xs = x_r[i-1];
      assign ys = y_r[i-1];
      assign zs = z_r[i-1];
      assign ns = neg_r[i-1];
    end
    assign dx  = ys >>> i;
    assign dy  = xs >>> i;
    assign ang = e2r_pkg::atan_q23(5'(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[31]) begin
          x_r[i] <= xs - dx;
          y_r[i] <= ys + dy;
          z_r[i] <= zs - ang;
        end else begin
          x_r[i] <= xs + dx;
          y_r[i] <= ys - dy;
          z_r[i] <= zs + ang;
        end
        neg_r[i] <= ns;
      end
    end
  end

  assign sc.s = y_r[STEPS-1];
  assign sc.c = neg_r[STEPS-1] ? -x_r[STEPS-1] : x_r[STEPS-1];

endmodule
`default_nettype wire

// File: hdl/e2r_matrix.sv
// Product, sum and output formatting stages that build the nine matrix entries.
`default_nettype none
module e2r_matrix #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire e2r_pkg::sincos_t  rl,
  input  wire e2r_pkg::sincos_t  pt,
  input  wire e2r_pkg::sincos_t  yw,
  output logic [143:0]           mat
);

  localparam int SH = e2r_pkg::WORK_FRAC - OUT_FRAC_BITS;

  e2r_pkg::q28_t cycp_r, cysp_r, sysp_r, sycp_r, cpsr_r, cpcr_r;
  e2r_pkg::q28_t sycr_r, sysr_r, cycr_r, cysr_r, sp_r, sr_r, cr_r;
  e2r_pkg::q28_t t01_r, t02_r, t11_r, t12_r;
  e2r_pkg::q28_t sycr2_r, sysr2_r, cycr2_r, cysr2_r, cycp2_r, sycp2_r;
  e2r_pkg::q28_t cpsr2_r, cpcr2_r, sp2_r;
  e2r_pkg::sum_t e_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      cycp_r <= e2r_pkg::qmul(yw.c, pt.c);
      cysp_r <= e2r_pkg::qmul(yw.c, pt.s);
      sysp_r <= e2r_pkg::qmul(yw.s, pt.s);
      sycp_r <= e2r_pkg::qmul(yw.s, pt.c);
      cpsr_r <= e2r_pkg::qmul(pt.c, rl.s);
      cpcr_r <= e2r_pkg::qmul(pt.c, rl.c);
      sycr_r <= e2r_pkg::qmul(yw.s, rl.c);
      sysr_r <= e2r_pkg::qmul(yw.s, rl.s);
      cycr_r <= e2r_pkg::qmul(yw.c, rl.c);
      cysr_r <= e2r_pkg::qmul(yw.c, rl.s);
      sp_r   <= pt.s;
      sr_r   <= rl.s;
      cr_r   <= rl.c;

      t01_r   <= e2r_pkg::qmul(cysp_r, sr_r);
      t02_r   <= e2r_pkg::qmul(cysp_r, cr_r);
      t11_r   <= e2r_pkg::qmul(sysp_r, sr_r);
      t12_r   <= e2r_pkg::qmul(sysp_r, cr_r);
      sycr2_r <= sycr_r;
      sysr2_r <= sysr_r;
      cycr2_r <= cycr_r;
      cysr2_r <= cysr_r;
      cycp2_r <= cycp_r;
      sycp2_r <= sycp_r;
      cpsr2_r <= cpsr_r;
      cpcr2_r <= cpcr_r;
      sp2_r   <= sp_r;

      e_r[0] <= 34'(cycp2_r);
      e_r[1] <= 34'(t01_r) - 34'(sycr2_r);
      e_r[2] <= 34'(t02_r) + 34'(sysr2_r);
      e_r[3] <= 34'(sycp2_r);
      e_r[4] <= 34'(t11_r) + 34'(cycr2_r);
      e_r[5] <= 34'(t12_r) - 34'(cysr2_r);
      e_r[6] <= -34'(sp2_r);
      e_r[7] <= 34'(cpsr2_r);
      e_r[8] <= 34'(cpcr2_r);
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_fmt
    logic signed [39:0] v, lim;
    always_comb begin
      lim = 40'sd1 <<< OUT_FRAC_BITS;
      if (SH > 0) begin
        v = (40'(e_r[k]) + (40'sd1 <<< (SH - 1))) >>> SH;
      end else begin
        v = 40'(e_r[k]) <<< (-SH);
      end
      if (v > lim) begin
        v = lim;
      end else if (v < -lim) begin
        v = -lim;
      end
    end
    assign mat[16*k +: 16] = v[15:0];
  end

endmodule
`default_nettype wire

// File: hdl/euler_to_rotation_matrix.sv
// Top level: Z-Y-X Euler angles to rotation matrix, fully pipelined.
//
// Channel   Direction  Contents
// in_*      input      roll, pitch, yaw angles (1/128 degree)
// out_*     output     nine matrix entries, row by row
//
// One transaction is accepted every cycle while the output is not stalled.
// The CORDIC pipeline depth (one stage per iteration) sets the latency.
// Reset clears the valid bits only; data registers hold whatever they held.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module euler_to_rotation_matrix #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  localparam int NSTEP = (CORDIC_STEPS > e2r_pkg::ATAN_ENTRIES) ?
                         e2r_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam int LAT   = NSTEP + 5;

  logic             adv;
  logic [LAT-1:0]   vld_r;
  logic [LAT-1:0]   vld_nxt;
  e2r_pkg::q28_t    z_r [3];
  logic             neg_r [3];
  e2r_pkg::sincos_t sc [3];
  logic [143:0]     mat;
  logic [143:0]     out_tdata_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign vld_nxt   = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_lane
    e2r_fold u_fold (
      .clk       (clk),
      .en        (adv),
      .angle     ($signed(in_tdata[16*a +: 16])),
      .z_r       (z_r[a]),
      .neg_cos_r (neg_r[a])
    );
    e2r_cordic #(.STEPS(NSTEP)) u_cordic (
      .clk        (clk),
      .en         (adv),
      .z_in       (z_r[a]),
      .neg_cos_in (neg_r[a]),
      .sc         (sc[a])
    );
  end

  e2r_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
    .clk (clk),
    .en  (adv),
    .rl  (sc[0]),
    .pt  (sc[1]),
    .yw  (sc[2]),
    .mat (mat)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= mat;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_tdata_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled while output empty");
  a_m20_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (OUT_FRAC_BITS > 14) ||
    ($signed(out_tdata[111:96]) <= 16'sd16384 && $signed(out_tdata[111:96]) >= -16'sd16384))
    else $error("m20 outside saturation range");

endmodule
`default_nettype wire
